@@ sv/sgn_pkg.sv @@
// Shared types and constants of the Sobel gradient normaliser.
`timescale 1ns / 1ps
package sgn_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam int RGB_W     = 24;
   localparam int PIX_W     = 8;
   localparam int GRAD_W    = 11;
   localparam int CFG_W     = 10;
   localparam int CSR_IDX_W = 1;
   localparam int QUOT_W    = 8;
   localparam int NUM_W     = GRAD_W + QUOT_W;
   localparam int NORM_SPAN = 254;
   localparam int MIN_DIM   = 3;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_READ,
      ST_LD_CALC,
      ST_LD_WRITE,
      ST_RD_ADDR,
      ST_RD_MEM,
      ST_RD_DATA,
      ST_RD_DIV
   } state_type;

   typedef struct packed {
      logic read;
      logic calc;
   } ld_ctrl_type;

endpackage

@@ sv/sgn_line_filter.sv @@
// Two-row value line store, 3x3 window and Sobel gradient for one loaded pixel.
`timescale 1ns / 1ps
module sgn_line_filter #(
   parameter int MAX_WIDTH = sgn_pkg::DEF_MAX_WIDTH
) (
   input  logic                                   clock,
   input  sgn_pkg::ld_ctrl_type                   ctrl,
   input  logic [$clog2(MAX_WIDTH)-1:0]           column,
   input  logic [sgn_pkg::RGB_W-1:0]              pixel_rgb,
   output logic [sgn_pkg::GRAD_W-1:0]             gradient
);
   import sgn_pkg::*;

   localparam int SUM_W = PIX_W + 2;

   // Each word holds {row above previous, previous row} for one column.
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] line_rd_ff;
   logic [PIX_W-1:0]   value_ff;
   logic [PIX_W-1:0]   w0_ff [3];
   logic [PIX_W-1:0]   w1_ff [3];
   logic [GRAD_W-1:0]  grad_ff;
   logic [PIX_W-1:0]   value_in;
   logic [PIX_W-1:0]   top, mid;
   logic [SUM_W-1:0]   s_bot, s_top, s_right, s_left;
   logic [SUM_W-1:0]   gy, gx;

   always_comb begin
      value_in = pixel_rgb[23:16];
      if (pixel_rgb[15:8] > value_in) begin
         value_in = pixel_rgb[15:8];
      end
      if (pixel_rgb[7:0] > value_in) begin
         value_in = pixel_rgb[7:0];
      end
   end

   assign mid = line_rd_ff[PIX_W-1:0];
   assign top = line_rd_ff[2*PIX_W-1:PIX_W];

   // Window columns after the shift: w0, w1, then the new column.
   assign s_bot   = SUM_W'(w0_ff[2]) + {1'b0, w1_ff[2], 1'b0} + SUM_W'(value_ff);
   assign s_top   = SUM_W'(w0_ff[0]) + {1'b0, w1_ff[0], 1'b0} + SUM_W'(top);
   assign s_right = SUM_W'(top) + {1'b0, mid, 1'b0} + SUM_W'(value_ff);
   assign s_left  = SUM_W'(w0_ff[0]) + {1'b0, w0_ff[1], 1'b0} + SUM_W'(w0_ff[2]);
   assign gy = (s_bot > s_top) ? s_bot - s_top : s_top - s_bot;
   assign gx = (s_right > s_left) ? s_right - s_left : s_left - s_right;

   always_ff @(posedge clock) begin
      if (ctrl.read) begin
         line_rd_ff <= line_mem[column];
         value_ff   <= value_in;
      end
      if (ctrl.calc) begin
         line_mem[column] <= {mid, value_ff};
         grad_ff <= GRAD_W'(gx) + GRAD_W'(gy);
         w0_ff   <= w1_ff;
         w1_ff[0] <= top;
         w1_ff[1] <= mid;
         w1_ff[2] <= value_ff;
      end
   end

   assign gradient = grad_ff;

endmodule

@@ sv/sgn_divider.sv @@
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module sgn_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sgn_pkg::NUM_W-1:0]     numerator,
   input  logic [sgn_pkg::GRAD_W-1:0]    divisor,
   output logic                          done,
   output logic [sgn_pkg::QUOT_W-1:0]    quotient
);
   import sgn_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   logic              active_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [GRAD_W-1:0] rem_ff;
   logic [GRAD_W-1:0] div_ff;
   logic [QUOT_W-1:0] num_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic              done_ff;
   logic [GRAD_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, num_ff[QUOT_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            count_ff  <= '0;
         end else if (active_ff) begin
            count_ff <= count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(QUOT_W - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff <= numerator[NUM_W-1:QUOT_W];
         num_ff <= numerator[QUOT_W-1:0];
         div_ff <= divisor;
      end else if (active_ff) begin
         rem_ff  <= fits ? GRAD_W'(trial - {1'b0, div_ff}) : GRAD_W'(trial);
         num_ff  <= {num_ff[QUOT_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUOT_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

@@ sv/sobel_gradient_normalizer.sv @@
// Top level of the Sobel gradient normaliser: control, frame store and readout.
`timescale 1ns / 1ps
// The block takes one frame of RGB pixels in raster order with load commands
// (req_command low) and then hands it back as gradient bytes, one per
// fetch command (req_command high). A command is transferred when start is high
// and busy is low. A load runs through a read of the line store, the
// Sobel sum and the write into the frame store with the minimum and maximum
// update. A fetch returns the stored gradient's low byte when the frame's gradient
// span is at most 254; when it is wider, the offset from the minimum is scaled
// to 0..254 by a divider yielding one quotient bit per cycle. Each result is shown on
// rsp_gray and rsp_last_pixel for exactly one cycle, marked by rsp_strobe; the
// receiver has to take it then, as there is no way to hold a result back.
// Fetches before the frame is complete and loads after it are taken but do
// nothing. The frame size is latched at the first load of a frame, so register
// writes take effect with the next frame. After the pixel flagged
// rsp_last_pixel the block is empty again and waits for a new frame.
module sobel_gradient_normalizer #(
   parameter int MAX_WIDTH  = sgn_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sgn_pkg::DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_command,
   input  logic [sgn_pkg::RGB_W-1:0]          req_pixel_rgb,
   output logic                               rsp_strobe,
   output logic [7:0]                         rsp_gray,
   output logic                               rsp_last_pixel,
   input  logic                               csr_write_enable,
   input  logic [sgn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sgn_pkg::CFG_W-1:0]          csr_write_data
);
   import sgn_pkg::*;

   localparam int X_W    = $clog2(MAX_WIDTH);
   localparam int Y_W    = $clog2(MAX_HEIGHT);
   localparam int DW     = $clog2(MAX_WIDTH + 1);
   localparam int DH     = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(DEPTH + 1);
   localparam int PROD_W = Y_W + DW;

   // Registers, latched frame size and frame counters.
   logic [CFG_W-1:0]  width_reg_ff, height_reg_ff;
   logic [DW-1:0]     frame_w_ff;
   logic [DH-1:0]     frame_h_ff;
   logic [DW-1:0]     clamp_w;
   logic [DH-1:0]     clamp_h;
   logic [X_W-1:0]    lx_ff, rx_ff;
   logic [Y_W-1:0]    ly_ff, ry_ff;
   logic [POS_W-1:0]  load_pos_ff;
   logic              loaded_ff;
   logic [GRAD_W-1:0] gmin_ff, gmax_ff;
   logic [RGB_W-1:0]  rgb_ff;
   logic              interior_ff;

   state_type         state_ff, state_in;
   ld_ctrl_type       ld_ctrl;
   logic              accept;
   logic              div_start, div_done;
   logic [QUOT_W-1:0] quot;
   logic [GRAD_W-1:0] grad;

   // Frame store and readout datapath.
   logic [GRAD_W-1:0] frame_mem [DEPTH];
   logic [GRAD_W-1:0] frame_rd_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic              frame_we;
   logic [X_W-1:0]    cx;
   logic [Y_W-1:0]    cy;
   logic [GRAD_W-1:0] span;
   logic              span_wide;
   logic [GRAD_W-1:0] diff;
   logic [NUM_W-1:0]  scaled;
   logic [7:0]        gray_ff;
   logic              lx_end, ly_end, rx_end, ry_end;
   logic              result_cycle;

   sgn_line_filter #(.MAX_WIDTH(MAX_WIDTH)) u_filter (
      .clock     (clock),
      .ctrl      (ld_ctrl),
      .column    (lx_ff),
      .pixel_rgb (rgb_ff),
      .gradient  (grad)
   );

   sgn_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (scaled),
      .divisor   (span),
      .done      (div_done),
      .quotient  (quot)
   );

   assign accept = start && !busy;

   // A size register below three counts as three, one above the maximum as the maximum.
   always_comb begin
      if (int'(width_reg_ff) < MIN_DIM) begin
         clamp_w = DW'(MIN_DIM);
      end else if (int'(width_reg_ff) > MAX_WIDTH) begin
         clamp_w = DW'(MAX_WIDTH);
      end else begin
         clamp_w = DW'(width_reg_ff);
      end
      if (int'(height_reg_ff) < MIN_DIM) begin
         clamp_h = DH'(MIN_DIM);
      end else if (int'(height_reg_ff) > MAX_HEIGHT) begin
         clamp_h = DH'(MAX_HEIGHT);
      end else begin
         clamp_h = DH'(height_reg_ff);
      end
   end

   assign lx_end = DW'(lx_ff) == frame_w_ff - DW'(1);
   assign ly_end = DH'(ly_ff) == frame_h_ff - DH'(1);
   assign rx_end = DW'(rx_ff) == frame_w_ff - DW'(1);
   assign ry_end = DH'(ry_ff) == frame_h_ff - DH'(1);

   // Border pixels read the nearest interior gradient.
   always_comb begin
      if (rx_ff == '0) begin
         cx = X_W'(1);
      end else if (DW'(rx_ff) > frame_w_ff - DW'(2)) begin
         cx = X_W'(frame_w_ff - DW'(2));
      end else begin
         cx = rx_ff;
      end
      if (ry_ff == '0) begin
         cy = Y_W'(1);
      end else if (DH'(ry_ff) > frame_h_ff - DH'(2)) begin
         cy = Y_W'(frame_h_ff - DH'(2));
      end else begin
         cy = ry_ff;
      end
   end

   assign wr_addr   = ADDR_W'(load_pos_ff - POS_W'(frame_w_ff) - POS_W'(1));
   assign span      = (gmax_ff > gmin_ff) ? gmax_ff - gmin_ff : '0;
   assign span_wide = span > GRAD_W'(NORM_SPAN);
   assign diff      = (frame_rd_ff > gmin_ff) ? frame_rd_ff - gmin_ff : '0;
   assign scaled    = NUM_W'(diff) * NUM_W'(NORM_SPAN);

   // The result cycle: a narrow span ends in the data state, a wide one in the divider.
   assign result_cycle = (state_ff == ST_RD_DATA && !span_wide) ||
                         (state_ff == ST_RD_DIV && div_done);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_LOAD && !loaded_ff) begin
                  state_in = ST_LD_READ;
               end else if (req_command == CMD_FETCH && loaded_ff) begin
                  state_in = ST_RD_ADDR;
               end
            end
         end
         ST_LD_READ:  state_in = ST_LD_CALC;
         ST_LD_CALC:  state_in = ST_LD_WRITE;
         ST_LD_WRITE: state_in = ST_IDLE;
         ST_RD_ADDR:  state_in = ST_RD_MEM;
         ST_RD_MEM:   state_in = ST_RD_DATA;
         ST_RD_DATA:  state_in = span_wide ? ST_RD_DIV : ST_IDLE;
         ST_RD_DIV: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      ld_ctrl   = '0;
      div_start = 1'b0;
      frame_we  = 1'b0;
      unique case (state_ff)
         ST_LD_READ:  ld_ctrl.read = 1'b1;
         ST_LD_CALC:  ld_ctrl.calc = 1'b1;
         ST_LD_WRITE: frame_we = interior_ff;
         ST_RD_DATA:  div_start = span_wide;
         default: ;
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[wr_addr] <= grad;
      end
      frame_rd_ff <= frame_mem[rd_addr_ff];
      if (accept) begin
         rgb_ff <= req_pixel_rgb;
      end
      if (state_ff == ST_RD_ADDR) begin
         rd_addr_ff <= ADDR_W'(PROD_W'(cy) * PROD_W'(frame_w_ff) + PROD_W'(cx));
      end
      if (state_ff == ST_LD_CALC) begin
         interior_ff <= (lx_ff >= X_W'(2)) && (ly_ff >= Y_W'(2));
      end
      if (state_ff == ST_RD_DATA) begin
         gray_ff <= frame_rd_ff[7:0];
      end else if (state_ff == ST_RD_DIV && div_done) begin
         gray_ff <= quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_reg_ff  <= CFG_W'(512);
         height_reg_ff <= CFG_W'(512);
         frame_w_ff    <= clamp_w;
         frame_h_ff    <= clamp_h;
         lx_ff         <= '0;
         ly_ff         <= '0;
         rx_ff         <= '0;
         ry_ff         <= '0;
         load_pos_ff   <= '0;
         loaded_ff     <= 1'b0;
         gmin_ff       <= '1;
         gmax_ff       <= '0;
         rsp_strobe    <= 1'b0;
         rsp_last_pixel <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_strobe     <= result_cycle;
         rsp_last_pixel <= result_cycle && rx_end && ry_end;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_IMAGE_WIDTH:  width_reg_ff  <= csr_write_data;
               REG_IMAGE_HEIGHT: height_reg_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (state_in == ST_LD_READ && load_pos_ff == '0) begin
            frame_w_ff <= clamp_w;
            frame_h_ff <= clamp_h;
         end
         if (state_ff == ST_LD_WRITE) begin
            if (interior_ff) begin
               if (grad > gmax_ff) begin
                  gmax_ff <= grad;
               end
               if (grad < gmin_ff) begin
                  gmin_ff <= grad;
               end
            end
            load_pos_ff <= load_pos_ff + POS_W'(1);
            if (lx_end) begin
               lx_ff <= '0;
               ly_ff <= ly_ff + Y_W'(1);
               if (ly_end) begin
                  loaded_ff <= 1'b1;
               end
            end else begin
               lx_ff <= lx_ff + X_W'(1);
            end
         end
         if (result_cycle) begin
            if (rx_end && ry_end) begin
               lx_ff       <= '0;
               ly_ff       <= '0;
               rx_ff       <= '0;
               ry_ff       <= '0;
               load_pos_ff <= '0;
               loaded_ff   <= 1'b0;
               gmin_ff     <= '1;
               gmax_ff     <= '0;
            end else if (rx_end) begin
               rx_ff <= '0;
               ry_ff <= ry_ff + Y_W'(1);
            end else begin
               rx_ff <= rx_ff + X_W'(1);
            end
         end
      end
   end

   assign rsp_gray = gray_ff;

endmodule

@@ sv/sgn_checker.sv @@
// Port-level checks of the Sobel gradient normaliser, bound to the top level.
`timescale 1ns / 1ps
module sgn_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last_pixel
);

   // A result closes a fetch, so the block was working in the cycle before it.
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result transfer without preceding work");

   // Results are single-cycle pulses, each from its own fetch.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // The frame flag only comes with a result.
   a_last_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_pixel |-> rsp_strobe)
      else $error("last pixel flag without a result");

   // Straight after reset the block is idle and shows no result.
   a_idle_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !busy && !rsp_strobe)
      else $error("block not idle after reset");

endmodule

bind sobel_gradient_normalizer sgn_checker u_sgn_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_last_pixel (rsp_last_pixel)
);
